// ----- hw/rtl/gmn_pkg.sv -----
`default_nettype none
package gmn_pkg;

    // norm_mode codes; code 3 decodes on bit 1 and acts as infinity
    localparam logic [1:0] NORM_L1  = 2'd0;
    localparam logic [1:0] NORM_L2  = 2'd1;
    localparam logic [1:0] NORM_INF = 2'd2;
    localparam logic [1:0] NORM_RESET = NORM_L2;

    localparam int GRAD_W    = 8;
    localparam int RAD_W     = 18;  // x*x + y*y < 2^17, padded to an even width
    localparam int ROOT_W    = RAD_W / 2;
    localparam int REM_W     = ROOT_W + 2;
    localparam int NUM_CELLS = ROOT_W;

    localparam logic [GRAD_W-1:0] MAG_MAX = 8'd255;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;      // radicand, consumed two bits per cell from the top
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic              use_root; // L2 selected for this beat
        logic [GRAD_W-1:0] alt;      // L1 or infinity result, already saturated
    } t_stage;

endpackage
`default_nettype wire

// ----- hw/rtl/gmn_if.sv -----
`default_nettype none
interface gmn_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] grad_x;
    logic [7:0] grad_y;
    modport source (output valid, output grad_x, output grad_y, input ready);
    modport sink   (input valid, input grad_x, input grad_y, output ready);
endinterface

interface gmn_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] norm_mode;
    modport source (output valid, output norm_mode, input ready);
    modport sink   (input valid, input norm_mode, output ready);
endinterface

interface gmn_mag_if;
    logic       valid;
    logic       ready;
    logic [7:0] mag;
    modport source (output valid, output mag, input ready);
    modport sink   (input valid, input mag, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/gmn_front.sv -----
`default_nettype none
module gmn_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_valid,
    input  wire logic [gmn_pkg::GRAD_W-1:0] i_grad_x,
    input  wire logic [gmn_pkg::GRAD_W-1:0] i_grad_y,
    input  wire logic [1:0]                 i_norm_mode,
    output logic                            o_valid,
    output gmn_pkg::t_stage                 o_stage
);

    logic [2*gmn_pkg::GRAD_W-1:0] sq_x;
    logic [2*gmn_pkg::GRAD_W-1:0] sq_y;
    logic [gmn_pkg::GRAD_W:0]     l1_sum;
    logic [gmn_pkg::GRAD_W-1:0]   l1_sat;
    logic [gmn_pkg::GRAD_W-1:0]   inf_max;
    gmn_pkg::t_stage              n_stage;
    logic                         r_valid;
    gmn_pkg::t_stage              r_stage;

    always_comb begin
        sq_x    = i_grad_x * i_grad_x;
        sq_y    = i_grad_y * i_grad_y;
        l1_sum  = {1'b0, i_grad_x} + {1'b0, i_grad_y};
        l1_sat  = l1_sum[gmn_pkg::GRAD_W] ? gmn_pkg::MAG_MAX : l1_sum[gmn_pkg::GRAD_W-1:0];
        inf_max = (i_grad_x > i_grad_y) ? i_grad_x : i_grad_y;

        n_stage.rad      = gmn_pkg::RAD_W'({1'b0, sq_x} + {1'b0, sq_y});
        n_stage.rem      = '0;
        n_stage.root     = '0;
        n_stage.use_root = (i_norm_mode == gmn_pkg::NORM_L2);
        n_stage.alt      = i_norm_mode[1] ? inf_max : l1_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule
`default_nettype wire

// ----- hw/rtl/gmn_sqrt_cell.sv -----
`default_nettype none
module gmn_sqrt_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire gmn_pkg::t_stage i_stage,
    output logic                 o_valid,
    output gmn_pkg::t_stage      o_stage
);

    localparam int WIDE_W = gmn_pkg::REM_W + 2;

    logic [WIDE_W-1:0] rem_sh;
    logic [WIDE_W-1:0] trial;
    logic [WIDE_W-1:0] diff;
    logic              take;
    gmn_pkg::t_stage   n_stage;
    logic              r_valid;
    gmn_pkg::t_stage   r_stage;

    // One restoring step: bring down the next radicand pair, try root*4+1.
    always_comb begin
        rem_sh = {i_stage.rem, i_stage.rad[gmn_pkg::RAD_W-1 -: 2]};
        trial  = WIDE_W'({i_stage.root, 2'b01});
        take   = (rem_sh >= trial);
        diff   = take ? (rem_sh - trial) : rem_sh;

        n_stage          = i_stage;
        n_stage.rad      = {i_stage.rad[gmn_pkg::RAD_W-3:0], 2'b00};
        n_stage.rem      = diff[gmn_pkg::REM_W-1:0];
        n_stage.root     = {i_stage.root[gmn_pkg::ROOT_W-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule
`default_nettype wire

// ----- hw/rtl/gradient_magnitude_norm.sv -----
// Channel  | Dir | Payload                   | Beat taken when
// i_pix    | in  | grad_x[7:0], grad_y[7:0]  | valid && ready
// i_cfg    | in  | norm_mode[1:0]            | valid && ready (ready held high)
// o_mag    | out | mag[7:0]                  | valid && ready
//
// One pixel per cycle while o_mag does not stall; each result passes through
// 11 registers: front stage (squares, L1, max), nine square-root cells (one root
// bit each), output register.
// The norm is sampled per beat at the input and travels with it.
// A stall at o_mag freezes the whole chain; i_pix.ready follows it.
// Reset (synchronous, active low) empties the chain and sets L2.
`default_nettype none
module gradient_magnitude_norm (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    gmn_pix_if.sink    i_pix,
    gmn_cfg_if.sink    i_cfg,
    gmn_mag_if.source  o_mag
);

    localparam int N = gmn_pkg::NUM_CELLS;

    logic [1:0]                 r_mode;
    logic                       en;
    logic [N:0]                 chain_valid;
    gmn_pkg::t_stage            chain_stage [N+1];
    gmn_pkg::t_stage            last;
    logic [gmn_pkg::GRAD_W-1:0] n_mag;
    logic                       r_out_valid;
    logic [gmn_pkg::GRAD_W-1:0] r_out_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= gmn_pkg::NORM_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_mode <= i_cfg.norm_mode;
        end
    end

    assign i_cfg.ready = 1'b1;

    assign en          = !r_out_valid || o_mag.ready;
    assign i_pix.ready = en;

    gmn_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (i_pix.valid),
        .i_grad_x    (i_pix.grad_x),
        .i_grad_y    (i_pix.grad_y),
        .i_norm_mode (r_mode),
        .o_valid     (chain_valid[0]),
        .o_stage     (chain_stage[0])
    );

    for (genvar g = 0; g < N; g++) begin : g_cell
        gmn_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (chain_valid[g]),
            .i_stage (chain_stage[g]),
            .o_valid (chain_valid[g+1]),
            .o_stage (chain_stage[g+1])
        );
    end

    always_comb begin
        last = chain_stage[N];
        if (last.use_root) begin
            n_mag = last.root[gmn_pkg::ROOT_W-1] ? gmn_pkg::MAG_MAX
                                                 : last.root[gmn_pkg::GRAD_W-1:0];
        end else begin
            n_mag = last.alt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= chain_valid[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_mag <= n_mag;
        end
    end

    assign o_mag.valid = r_out_valid;
    assign o_mag.mag   = r_out_mag;

endmodule
`default_nettype wire

// ----- hw/rtl/gmn_checker.sv -----
`default_nettype none
module gmn_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_pix_ready,
    input wire logic       i_cfg_ready,
    input wire logic       i_mag_valid,
    input wire logic       i_mag_ready,
    input wire logic [7:0] i_mag_data
);

    // a stalled result beat holds
    ast_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_mag_valid && !i_mag_ready |=> i_mag_valid && $stable(i_mag_data))
        else $error("result beat changed under stall");

    // input side opens exactly when the output register can move
    ast_ready_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix_ready == (!i_mag_valid || i_mag_ready))
        else $error("input ready does not follow output stall");

    // chain is empty right after reset
    ast_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_mag_valid)
        else $error("result valid after reset");

    // config writes are never back-pressured
    ast_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("config channel not ready");

endmodule

bind gradient_magnitude_norm gmn_checker u_gmn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_pix_ready (i_pix.ready),
    .i_cfg_ready (i_cfg.ready),
    .i_mag_valid (o_mag.valid),
    .i_mag_ready (o_mag.ready),
    .i_mag_data  (o_mag.mag)
);
`default_nettype wire

// ----- test/tb_gradient_magnitude_norm.sv -----
module tb_gradient_magnitude_norm;
    timeunit 1ns;
    timeprecision 1ps;

    // code 3 is outside the defined set; the block decodes it on bit 1
    localparam logic [1:0] NORM_UNDEF = 2'd3;
    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL_CYCLES = 20;

    logic i_clk;
    logic i_rst_n;

    gmn_pix_if pix_if();
    gmn_cfg_if cfg_if();
    gmn_mag_if mag_if();

    gradient_magnitude_norm DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .i_cfg   (cfg_if),
        .o_mag   (mag_if)
    );

    logic [1:0] norm_shadow;
    logic [7:0] magnitude_queue[$];
    int error_count;
    int idle_cycles;
    int send_idle_pct;
    int stall_pct;
    int hold_req;
    int hold_left;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic logic [7:0] l2_magnitude(logic [7:0] gx, logic [7:0] gy);
        logic [17:0] sum_sq;
        logic [8:0] root;
        logic [8:0] trial;
        int b;
        sum_sq = gx * gx + gy * gy;
        root = '0;
        // largest root with root*root <= sum_sq, one bit at a time from the top
        for (b = 8; b >= 0; b--) begin
            trial = root | (9'd1 << b);
            if (trial * trial <= sum_sq) root = trial;
        end
        return (root > gmn_pkg::MAG_MAX) ? gmn_pkg::MAG_MAX : root[7:0];
    endfunction

    function automatic logic [7:0] predict_magnitude(logic [1:0] mode, logic [7:0] gx,
                                                     logic [7:0] gy);
        logic [8:0] sum;
        case (mode)
            gmn_pkg::NORM_L1: begin
                sum = gx + gy;
                return (sum > gmn_pkg::MAG_MAX) ? gmn_pkg::MAG_MAX : sum[7:0];
            end
            gmn_pkg::NORM_L2: return l2_magnitude(gx, gy);
            default: return (gx > gy) ? gx : gy;  // infinity, undefined code too
        endcase
    endfunction

    function automatic logic [7:0] rand_grad();
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'd255 : 8'd0;
        return 8'($urandom_range(0, 255));
    endfunction

    // sample every channel at the rising edge; DUT outputs still hold pre-edge values
    always @(posedge i_clk) begin : monitor
        logic [7:0] want;
        logic beat;
        beat = 1'b0;
        if (!i_rst_n) begin
            norm_shadow = gmn_pkg::NORM_RESET;
        end else begin
            if (pix_if.valid && pix_if.ready) begin
                magnitude_queue.push_back(predict_magnitude(norm_shadow, pix_if.grad_x,
                                                            pix_if.grad_y));
                beat = 1'b1;
            end
            if (cfg_if.valid && cfg_if.ready) begin
                norm_shadow = cfg_if.norm_mode;
                beat = 1'b1;
            end
            if (mag_if.valid && mag_if.ready) begin
                beat = 1'b1;
                if (magnitude_queue.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected magnitude beat, actual %0d", $time,
                             mag_if.mag);
                end else begin
                    want = magnitude_queue.pop_front();
                    if (mag_if.mag !== want) begin
                        error_count++;
                        $display("%0t: magnitude mismatch, expected %0d actual %0d",
                                 $time, want, mag_if.mag);
                    end
                end
            end
        end
        idle_cycles = beat ? 0 : idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // output side: random stalls, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            mag_if.ready <= 1'b0;
            hold_left--;
        end else begin
            mag_if.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // all tasks are entered and left at a falling edge
    task automatic send_pixel(input logic [7:0] gx, input logic [7:0] gy);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            pix_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.grad_x <= gx;
        pix_if.grad_y <= gy;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_pixels();
        pix_if.valid <= 1'b0;
        while (magnitude_queue.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_norm_mode(input logic [1:0] mode);
        drain_pixels();
        cfg_if.valid <= 1'b1;
        cfg_if.norm_mode <= mode;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic test_reset_mode();
        send_pixel(8'd0, 8'd0);
        send_pixel(8'd3, 8'd4);
        send_pixel(8'd1, 8'd1);      // root truncated
        send_pixel(8'd180, 8'd180);
        send_pixel(8'd255, 8'd255);  // root above 255 saturates
        drain_pixels();
    endtask

    task automatic test_directed_modes();
        write_norm_mode(gmn_pkg::NORM_L1);
        send_pixel(8'd0, 8'd0);
        send_pixel(8'd128, 8'd127);  // exactly full scale
        send_pixel(8'd200, 8'd100);  // sum overflow
        send_pixel(8'd255, 8'd255);
        write_norm_mode(gmn_pkg::NORM_INF);
        send_pixel(8'd200, 8'd100);
        send_pixel(8'd100, 8'd200);
        send_pixel(8'd255, 8'd255);
        send_pixel(8'd0, 8'd0);
        write_norm_mode(NORM_UNDEF);
        send_pixel(8'd7, 8'd200);
        send_pixel(8'd200, 8'd7);
        send_pixel(8'd85, 8'd170);
        write_norm_mode(gmn_pkg::NORM_L2);
        send_pixel(8'd170, 8'd85);
        send_pixel(8'd255, 8'd0);
        send_pixel(8'd0, 8'd255);
        drain_pixels();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_in, input int n);
        int m;
        int k;
        send_idle_pct = idle_pct;
        stall_pct = stall_in;
        for (m = 0; m < 4; m++) begin
            case ($urandom_range(0, 3))
                0: write_norm_mode(gmn_pkg::NORM_L1);
                1: write_norm_mode(gmn_pkg::NORM_L2);
                2: write_norm_mode(gmn_pkg::NORM_INF);
                default: write_norm_mode(NORM_UNDEF);
            endcase
            for (k = 0; k < n; k++) send_pixel(rand_grad(), rand_grad());
        end
        drain_pixels();
    endtask

    // output held off long enough that the chain fills and input ready drops
    task automatic test_output_hold();
        int k;
        send_idle_pct = 0;
        stall_pct = 0;
        write_norm_mode(gmn_pkg::NORM_L2);
        hold_req = 60;
        for (k = 0; k < 40; k++) send_pixel(rand_grad(), rand_grad());
        drain_pixels();
        for (k = 0; k < 20; k++) send_pixel(rand_grad(), rand_grad());
        drain_pixels();
    endtask

    initial begin
        error_count = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_req = 0;
        hold_left = 0;
        i_rst_n = 1'b0;
        pix_if.valid = 1'b0;
        pix_if.grad_x = '0;
        pix_if.grad_y = '0;
        cfg_if.valid = 1'b0;
        cfg_if.norm_mode = gmn_pkg::NORM_RESET;
        mag_if.ready = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_mode();
        test_directed_modes();
        test_random_traffic(0, 0, 20);
        test_random_traffic(68, 0, 20);
        test_random_traffic(0, 68, 20);
        test_random_traffic(12, 12, 20);
        test_output_hold();
        write_norm_mode(gmn_pkg::NORM_L1);

        drain_pixels();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
